// ----- sv/message_stream_deframer_unit_macros.svh -----
// Assertion helpers for the message stream deframer
`ifndef MESSAGE_STREAM_DEFRAMER_UNIT_MACROS_SVH
`define MESSAGE_STREAM_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MSDU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define MSDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MSDU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSDU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/msd_pkg.sv -----
package msd_pkg;

  localparam int COUNT_BITS_DEFAULT = 25;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOWEST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGHEST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd3;

  localparam logic [31:0] MAGIC_WORD_RESET   = 32'h3154_5749;
  localparam logic [7:0]  TYPE_LOWEST_RESET  = 8'd0;
  localparam logic [7:0]  TYPE_HIGHEST_RESET = 8'd3;
  localparam logic [24:0] MAX_PAYLOAD_RESET  = 25'h100_0000;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // index of the last header byte
  localparam logic [3:0] HEADER_LAST = 4'd11;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  type_lowest;
    logic [7:0]  type_highest;
    logic [24:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] mtype;
    logic       first;
    logic       last;
  } result_t;

endpackage

// ----- sv/msd_cfg_regs.sv -----
module msd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output msd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word   <= msd_pkg::MAGIC_WORD_RESET;
      cfg.type_lowest  <= msd_pkg::TYPE_LOWEST_RESET;
      cfg.type_highest <= msd_pkg::TYPE_HIGHEST_RESET;
      cfg.max_payload  <= msd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msd_pkg::CFG_MAGIC_WORD:   cfg.magic_word   <= cfg_data;
        msd_pkg::CFG_TYPE_LOWEST:  cfg.type_lowest  <= cfg_data[7:0];
        msd_pkg::CFG_TYPE_HIGHEST: cfg.type_highest <= cfg_data[7:0];
        msd_pkg::CFG_MAX_PAYLOAD:  cfg.max_payload  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/msd_deframe.sv -----
module msd_deframe #(
  parameter int COUNT_BITS = msd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       byte_in,
  input  msd_pkg::cfg_t    cfg,
  input  logic             res_ready,
  output logic             res_valid,
  output msd_pkg::result_t res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_ERROR   = 2'd2;

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic [1:0]            phase, phase_next;
  logic [3:0]            header_count, header_count_next;
  logic [31:0]           magic_shift, magic_shift_next;
  logic [31:0]           type_shift, type_shift_next;
  logic [31:0]           length_shift, length_shift_next;
  logic [COUNT_BITS-1:0] payload_remaining, payload_remaining_next;
  logic                  at_first_byte, at_first_byte_next;

  logic        proc;
  logic        last_byte;
  logic        header_ok;
  logic [31:0] len_upd;

  assign proc     = s1_valid && res_ready;
  assign in_ready = !s1_valid || res_ready;
  assign len_upd  = {s1_byte, length_shift[31:8]};

  assign last_byte = payload_remaining <= COUNT_BITS'(1);

  assign header_ok = (magic_shift == cfg.magic_word)
                  && (type_shift >= {24'd0, cfg.type_lowest})
                  && (type_shift <= {24'd0, cfg.type_highest})
                  && (len_upd <= {7'd0, cfg.max_payload})
                  && ((len_upd >> COUNT_BITS) == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_count      <= 4'd0;
      magic_shift       <= 32'd0;
      type_shift        <= 32'd0;
      length_shift      <= 32'd0;
      payload_remaining <= '0;
      at_first_byte     <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      magic_shift       <= magic_shift_next;
      type_shift        <= type_shift_next;
      length_shift      <= length_shift_next;
      payload_remaining <= payload_remaining_next;
      at_first_byte     <= at_first_byte_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    magic_shift_next       = magic_shift;
    type_shift_next        = type_shift;
    length_shift_next      = length_shift;
    payload_remaining_next = payload_remaining;
    at_first_byte_next     = at_first_byte;
    res_valid              = 1'b0;
    res                    = '0;
    if (proc) begin
      case (phase)
        PH_PAYLOAD: begin
          res_valid          = 1'b1;
          res.kind           = msd_pkg::KIND_PAYLOAD;
          res.data           = s1_byte;
          res.mtype          = type_shift[7:0];
          res.first          = at_first_byte;
          res.last           = last_byte;
          at_first_byte_next = 1'b0;
          if (last_byte) begin
            payload_remaining_next = '0;
            phase_next             = PH_HEADER;
            header_count_next      = 4'd0;
          end else begin
            payload_remaining_next = payload_remaining - COUNT_BITS'(1);
          end
        end
        PH_HEADER: begin
          if (header_count < 4'd4) begin
            magic_shift_next = {s1_byte, magic_shift[31:8]};
          end else if (header_count < 4'd8) begin
            type_shift_next = {s1_byte, type_shift[31:8]};
          end else begin
            length_shift_next = len_upd;
          end
          if (header_count == msd_pkg::HEADER_LAST) begin
            header_count_next = 4'd0;
            if (!header_ok) begin
              phase_next = PH_ERROR;
              res_valid  = 1'b1;
              res.kind   = msd_pkg::KIND_ERROR;
            end else if (len_upd == 32'd0) begin
              res_valid = 1'b1;
              res.kind  = msd_pkg::KIND_EMPTY;
              res.mtype = type_shift[7:0];
              res.last  = 1'b1;
            end else begin
              payload_remaining_next = len_upd[COUNT_BITS-1:0];
              at_first_byte_next     = 1'b1;
              phase_next             = PH_PAYLOAD;
            end
          end else begin
            header_count_next = header_count + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/msd_out_reg.sv -----
module msd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  msd_pkg::result_t res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msd_pkg::result_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- sv/message_stream_deframer_unit.sv -----
// Message stream deframer: takes one raw byte per clock on the input channel
// (while the output is not held off) and strips 12-byte little-endian headers
// (magic, type, length). Payload bytes come out as they arrive, marked
// first/last and tagged with the message type; a zero-length message gives one
// empty-message result and a bad header gives one error result, after which
// all bytes are dropped until reset. Sustained rate is one byte per clock
// while the output is not held off. A transferred byte is decoded while it
// sits in the input register, and any result it causes is loaded into the
// result register; that result is offered on the output in the next cycle.
// The header check runs while the last header byte sits in the input register.
// While the output is held off the block keeps one byte and one result, then
// stalls its input. No start-up delay after reset. Registers may be written
// only while the block is idle.
`include "message_stream_deframer_unit_macros.svh"

module message_stream_deframer_unit #(
  parameter int COUNT_BITS = msd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     byte_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     result_kind,
  output logic [7:0]                     data_byte,
  output logic [7:0]                     msg_type,
  output logic                           first_of_message,
  output logic                           last_of_message,
  input  logic                           cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data
);

  msd_pkg::cfg_t    cfg;
  msd_pkg::result_t res;
  msd_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;

  msd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msd_deframe #(
    .COUNT_BITS (COUNT_BITS)
  ) u_deframe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  msd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign result_kind      = out_res.kind;
  assign data_byte        = out_res.data;
  assign msg_type         = out_res.mtype;
  assign first_of_message = out_res.first;
  assign last_of_message  = out_res.last;

  `MSDU_ASSERT_IMPL(a_error_clean, clk, rst,
    out_valid && result_kind == msd_pkg::KIND_ERROR,
    data_byte == 8'd0 && msg_type == 8'd0 && !first_of_message && !last_of_message)
  `MSDU_ASSERT_IMPL(a_empty_marks, clk, rst,
    out_valid && result_kind == msd_pkg::KIND_EMPTY,
    data_byte == 8'd0 && !first_of_message && last_of_message)
  `MSDU_ASSERT_NEXT(a_error_sticky, clk, rst,
    out_valid && out_ready && result_kind == msd_pkg::KIND_ERROR, !out_valid)
  `MSDU_ASSERT_IMPL(a_result_needs_room, clk, rst, res_valid, res_ready)

endmodule
